[rtl/waypoint_pursuit_controller_assert.svh]
// Assertion macros shared by the controller RTL.
`ifndef WAYPOINT_PURSUIT_CONTROLLER_ASSERT_SVH
`define WAYPOINT_PURSUIT_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define WPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("controller assertion failed");

// Next-cycle implication.
`define WPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("controller assertion failed");

`endif

[rtl/wpc_pkg.sv]
package wpc_pkg;

  localparam int CfgIdxWidth = 2;
  localparam logic [CfgIdxWidth-1:0] REG_LINEAR_GAIN  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_ANGULAR_GAIN = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_ARRIVAL      = 2'd2;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_ODOMETRY = 1'b1;

  localparam logic [23:0] LINEAR_GAIN_RESET  = 24'd32768;
  localparam logic [23:0] ANGULAR_GAIN_RESET = 24'd65536;
  localparam logic [23:0] ARRIVAL_RESET      = 24'd6554;

  // Pi in Q16.16.
  localparam logic signed [18:0] PI_Q16 = 19'sd205887;
  localparam logic [15:0] HALF_TURN = 16'd32768;

  typedef struct packed {
    logic start;
    logic step;
  } cordic_ctl_t;

  function automatic logic [15:0] atan_step(input logic [3:0] i);
    logic [15:0] a;
    case (i)
      4'd0:  a = 16'd8192;
      4'd1:  a = 16'd4836;
      4'd2:  a = 16'd2555;
      4'd3:  a = 16'd1297;
      4'd4:  a = 16'd651;
      4'd5:  a = 16'd326;
      4'd6:  a = 16'd163;
      4'd7:  a = 16'd81;
      4'd8:  a = 16'd41;
      4'd9:  a = 16'd20;
      4'd10: a = 16'd10;
      4'd11: a = 16'd5;
      4'd12: a = 16'd3;
      4'd13: a = 16'd1;
      4'd14: a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage

[rtl/wpc_if.sv]
interface wpc_item_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic               new_path;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  modport source (output valid, operation, new_path, pos_x, pos_y, heading, input ready);
  modport sink (input valid, operation, new_path, pos_x, pos_y, heading, output ready);
endinterface

interface wpc_result_if;
  logic               valid;
  logic               ready;
  logic [23:0]        fwd_speed;
  logic signed [24:0] turn_rate;
  logic [7:0]         target_index;
  modport source (output valid, fwd_speed, turn_rate, target_index, input ready);
  modport sink (input valid, fwd_speed, turn_rate, target_index, output ready);
endinterface

interface wpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/wpc_cordic.sv]
// Vectoring CORDIC: one micro-rotation per step, sixteen steps per bearing.
module wpc_cordic (
  input  logic                  clk,
  input  wpc_pkg::cordic_ctl_t  ctl,
  input  logic signed [32:0]    dx,
  input  logic signed [32:0]    dy,
  output logic [15:0]           bearing
);

  logic signed [35:0] x;
  logic signed [35:0] y;
  logic [15:0]        z;
  logic [3:0]         i;
  logic               zero_vec;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      zero_vec <= (dx == '0) && (dy == '0);
      i        <= '0;
      if (dx < 0) begin
        x <= -36'(dx);
        y <= -36'(dy);
        z <= wpc_pkg::HALF_TURN;
      end else begin
        x <= 36'(dx);
        y <= 36'(dy);
        z <= '0;
      end
    end else if (ctl.step) begin
      i <= i + 4'd1;
      if (y >= 0) begin
        x <= x + (y >>> i);
        y <= y - (x >>> i);
        z <= z + wpc_pkg::atan_step(i);
      end else begin
        x <= x - (y >>> i);
        y <= y + (x >>> i);
        z <= z - wpc_pkg::atan_step(i);
      end
    end
  end

  assign bearing = zero_vec ? '0 : z;

endmodule

[rtl/waypoint_pursuit_controller.sv]
// Sequencing: a waypoint load is written as it is accepted; an odometry request moves
// through the read, squaring, 31-step square root (beside the 16-step CORDIC), multiply
// and done states. Items are taken only while idle, one load per cycle; a finished command
// waits in the output register while the next request is taken.
// Reset (synchronous, active high) empties the path, zeroes the target and restores the
// default gains; waypoint memory contents are not cleared and need no clearing pass.
module waypoint_pursuit_controller #(
  parameter int PATH_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  wpc_item_if.sink      item,
  wpc_result_if.source  result,
  wpc_cfg_if.sink       cfg
);

  localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam logic [AW:0] DEPTH_VAL = (AW+1)'(PATH_DEPTH);

  // Sequencer codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SQX  = 3'd2;
  localparam logic [2:0] S_SQY  = 3'd3;
  localparam logic [2:0] S_ITER = 3'd4;
  localparam logic [2:0] S_MULA = 3'd5;
  localparam logic [2:0] S_MULB = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  localparam logic [4:0] LAST_ITER   = 5'd30;
  localparam logic [4:0] CORDIC_STEPS = 5'd16;

  // Configuration registers; writes are always taken.
  logic [23:0] gain_l;
  logic [23:0] gain_a;
  logic [23:0] radius;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_l <= wpc_pkg::LINEAR_GAIN_RESET;
      gain_a <= wpc_pkg::ANGULAR_GAIN_RESET;
      radius <= wpc_pkg::ARRIVAL_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        wpc_pkg::REG_LINEAR_GAIN:  gain_l <= cfg.data;
        wpc_pkg::REG_ANGULAR_GAIN: gain_a <= cfg.data;
        wpc_pkg::REG_ARRIVAL:      radius <= cfg.data;
        default: ;
      endcase
    end
  end

  // The waypoint table holds x in the upper half and y in the lower half of each word.
  logic [63:0] wp_mem [PATH_DEPTH];
  logic [63:0] rd_data;

  logic [2:0]  state;
  logic [AW:0] path_len;
  logic [AW-1:0] target;

  logic accept;
  logic is_load;
  logic is_odo;
  logic wr_en;
  logic [AW-1:0] wr_addr;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign is_load    = accept && (item.operation == wpc_pkg::OP_LOAD);
  assign is_odo     = accept && (item.operation == wpc_pkg::OP_ODOMETRY);
  // A new path always stores at the head; otherwise the table appends until full.
  assign wr_en      = is_load && (item.new_path || (path_len < DEPTH_VAL));
  assign wr_addr    = item.new_path ? '0 : path_len[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wp_mem[wr_addr] <= {item.pos_x, item.pos_y};
    end
  end

  always_ff @(posedge clk) begin
    if (is_odo) begin
      rd_data <= wp_mem[target];
    end
  end

  // Captured robot pose for the request in flight.
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic [15:0]        yaw;

  // Datapath registers.
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic               sat;
  logic [59:0]        sq;
  logic [61:0]        rem;
  logic [61:0]        root;
  logic [61:0]        bitm;
  logic [4:0]         iter;
  logic [55:0]        lin_prod;
  logic signed [40:0] ang_p1;
  logic signed [59:0] ang_p2;
  logic               arrive;

  logic [29:0] ax;
  logic [29:0] ay;
  logic [61:0] trial;
  logic [31:0] distance;
  logic [15:0] bearing;
  logic signed [15:0] err;
  logic [39:0] lin_full;
  logic [23:0] lin;
  logic signed [28:0] ang_full;
  logic signed [28:0] ga_ext;
  logic signed [24:0] ang;

  wpc_pkg::cordic_ctl_t cordic_ctl;

  assign ax       = dx[32] ? 30'(-dx) : dx[29:0];
  assign ay       = dy[32] ? 30'(-dy) : dy[29:0];
  assign trial    = root + bitm;
  assign distance = sat ? '1 : root[31:0];
  assign err      = signed'(bearing - yaw);

  assign lin_full = lin_prod[55:16];
  assign lin      = (lin_full > 40'(gain_l)) ? gain_l : lin_full[23:0];

  // Floor of the product over 2^31, clamped to the symmetric gain.
  assign ang_full = ang_p2[59:31];
  assign ga_ext   = signed'(29'(gain_a));
  always_comb begin
    if (ang_full > ga_ext) begin
      ang = signed'({1'b0, gain_a});
    end else if (ang_full < -ga_ext) begin
      ang = -signed'({1'b0, gain_a});
    end else begin
      ang = ang_full[24:0];
    end
  end

  assign cordic_ctl.start = (state == S_SQX);
  assign cordic_ctl.step  = (state == S_ITER) && (iter < CORDIC_STEPS);

  wpc_cordic u_cordic (
    .clk     (clk),
    .ctl     (cordic_ctl),
    .dx      (dx),
    .dy      (dy),
    .bearing (bearing)
  );

  logic        res_valid;
  logic [23:0] res_lin;
  logic signed [24:0] res_ang;
  logic [7:0]  res_idx;

  assign result.valid        = res_valid;
  assign result.fwd_speed    = res_lin;
  assign result.turn_rate    = res_ang;
  assign result.target_index = res_idx;

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      path_len  <= '0;
      target    <= '0;
      res_valid <= 1'b0;
    end else begin
      // A new command replaces one that leaves in the same cycle.
      if ((state == S_DONE) && (!res_valid || result.ready)) begin
        res_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (is_load) begin
            if (item.new_path) begin
              path_len <= (AW+1)'(1);
              target   <= '0;
            end else if (path_len < DEPTH_VAL) begin
              path_len <= path_len + (AW+1)'(1);
            end
          end else if (is_odo && (path_len != '0)) begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_SQX;
        S_SQX:  state <= S_SQY;
        S_SQY:  state <= S_ITER;
        S_ITER: begin
          if (iter == LAST_ITER) begin
            state <= S_MULA;
          end
        end
        S_MULA: state <= S_MULB;
        S_MULB: state <= S_DONE;
        S_DONE: begin
          if (!res_valid || result.ready) begin
            state <= S_IDLE;
            if (arrive && ((AW+1)'(target) + (AW+1)'(1) < path_len)) begin
              target <= target + AW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Arithmetic datapath, stepped by the sequencer through the iterative square root.
  always_ff @(posedge clk) begin
    if (is_odo) begin
      px  <= item.pos_x;
      py  <= item.pos_y;
      yaw <= item.heading;
    end
    case (state)
      S_READ: begin
        dx <= 33'(signed'(rd_data[63:32])) - 33'(px);
        dy <= 33'(signed'(rd_data[31:0])) - 33'(py);
      end
      S_SQX: begin
        sat <= (dx >= 33'sd1073741824) || (dx <= -33'sd1073741824) ||
               (dy >= 33'sd1073741824) || (dy <= -33'sd1073741824);
        sq  <= ax * ax;
      end
      S_SQY: begin
        rem  <= 62'(sq) + 62'(ay * ay);
        root <= '0;
        bitm <= 62'(1) << 60;
        iter <= '0;
      end
      S_ITER: begin
        iter <= iter + 5'd1;
        bitm <= bitm >> 2;
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bitm;
        end else begin
          root <= root >> 1;
        end
      end
      S_MULA: begin
        lin_prod <= 56'(gain_l) * 56'(distance);
        ang_p1   <= 41'(signed'({1'b0, gain_a})) * 41'(err);
        arrive   <= distance < 32'(radius);
      end
      S_MULB: begin
        ang_p2 <= 60'(ang_p1) * 60'(wpc_pkg::PI_Q16);
      end
      S_DONE: begin
        if (!res_valid || result.ready) begin
          res_lin <= lin;
          res_ang <= ang;
          res_idx <= 8'(target);
        end
      end
      default: ;
    endcase
  end

  `include "waypoint_pursuit_controller_assert.svh"

  `WPC_ASSERT_IMP(a_target_in_path, path_len != '0, (AW+1)'(target) < path_len)
  `WPC_ASSERT_IMP(a_len_bounded, 1'b1, path_len <= DEPTH_VAL)
  `WPC_ASSERT_NXT(a_empty_no_work, is_odo && (path_len == '0), state == S_IDLE)

endmodule

[tb/waypoint_pursuit_controller_checker.sv]
`timescale 1ns / 1ps

module waypoint_pursuit_controller_checker #(
  parameter int PATH_DEPTH = 256
) (
  input  logic  clk,
  input  logic  rst,
  wpc_item_if   item,
  wpc_result_if result,
  wpc_cfg_if    cfg,
  output int    pending,
  output int    errors
);

  typedef struct {
    logic [23:0]        lin;
    logic signed [24:0] ang;
    logic [7:0]         idx;
  } command_t;

  command_t command_q[$];

  logic signed [31:0] path_x [PATH_DEPTH];
  logic signed [31:0] path_y [PATH_DEPTH];
  int unsigned path_len;
  int unsigned target;
  logic [23:0] lin_gain;
  logic [23:0] ang_gain;
  logic [23:0] arrive_dist;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC on the offset, result as a binary angle.
  function automatic logic [15:0] heading_to(longint dx, longint dy);
    longint vx;
    longint vy;
    longint nx;
    logic [15:0] z;
    z = 16'd0;
    vx = dx;
    vy = dy;
    if (dx == 0 && dy == 0) return 16'd0;
    if (dx < 0) begin
      vx = -dx;
      vy = -dy;
      z = wpc_pkg::HALF_TURN;
    end
    for (int i = 0; i < 16; i++) begin
      if (vy >= 0) begin
        nx = vx + (vy >>> i);
        vy = vy - (vx >>> i);
        z = z + wpc_pkg::atan_step(4'(i));
      end else begin
        nx = vx - (vy >>> i);
        vy = vy + (vx >>> i);
        z = z - wpc_pkg::atan_step(4'(i));
      end
      vx = nx;
    end
    return z;
  endfunction

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic predict_request();
    int unsigned tgt;
    longint dx;
    longint dy;
    longint unsigned distance;
    longint unsigned lin;
    longint ga;
    longint err;
    longint ang;
    logic [15:0] diff;
    command_t c;
    if (item.operation == wpc_pkg::OP_LOAD) begin
      if (item.new_path) begin
        path_len = 0;
        target = 0;
      end
      if (path_len < PATH_DEPTH) begin
        path_x[path_len] = item.pos_x;
        path_y[path_len] = item.pos_y;
        path_len++;
      end
      return;
    end
    // Odometry on an empty path gives no command.
    if (path_len == 0) return;
    tgt = (target < path_len) ? target : path_len - 1;
    dx = longint'(path_x[tgt]) - longint'(item.pos_x);
    dy = longint'(path_y[tgt]) - longint'(item.pos_y);
    if (dx >= (64'sd1 <<< 30) || dx <= -(64'sd1 <<< 30) ||
        dy >= (64'sd1 <<< 30) || dy <= -(64'sd1 <<< 30))
      distance = 64'hFFFF_FFFF;
    else
      distance = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
    lin = (longint'(lin_gain) * distance) >> 16;
    if (lin > lin_gain) lin = lin_gain;
    diff = heading_to(dx, dy) - item.heading;
    err = longint'($signed(diff));
    ga = longint'(ang_gain);
    ang = (ga * err * 205887) >>> 31;
    if (ang > ga) ang = ga;
    if (ang < -ga) ang = -ga;
    c.lin = lin[23:0];
    c.ang = ang[24:0];
    c.idx = tgt[7:0];
    command_q.push_back(c);
    if (distance < arrive_dist && tgt + 1 < path_len) target = tgt + 1;
    else target = tgt;
  endtask

  task automatic check_command();
    command_t c;
    if (command_q.size() == 0) begin
      report("command with nothing pending");
      return;
    end
    c = command_q.pop_front();
    if (result.fwd_speed !== c.lin)
      report($sformatf("fwd_speed %0h, predicted %0h", result.fwd_speed, c.lin));
    if (result.turn_rate !== c.ang)
      report($sformatf("turn_rate %0d, predicted %0d", result.turn_rate, c.ang));
    if (result.target_index !== c.idx)
      report($sformatf("target_index %0d, predicted %0d", result.target_index, c.idx));
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      command_q.delete();
      path_len = 0;
      target = 0;
      lin_gain = wpc_pkg::LINEAR_GAIN_RESET;
      ang_gain = wpc_pkg::ANGULAR_GAIN_RESET;
      arrive_dist = wpc_pkg::ARRIVAL_RESET;
    end else begin
      if (result.valid && result.ready) check_command();
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          wpc_pkg::REG_LINEAR_GAIN: lin_gain = cfg.data;
          wpc_pkg::REG_ANGULAR_GAIN: ang_gain = cfg.data;
          wpc_pkg::REG_ARRIVAL: arrive_dist = cfg.data;
          default: ;
        endcase
      end
      if (item.valid && item.ready) predict_request();
    end
    pending = command_q.size();
  end

endmodule

[tb/waypoint_pursuit_controller_tb.sv]
`timescale 1ns / 1ps

// Top of the controller bench. It builds paths of waypoints, sends odometry
// near them and rewrites the gains between phases; the checker beside the
// block predicts every command and counts the mismatches.
module waypoint_pursuit_controller_tb;

  // Index 3 names no register; the block must ignore a write to it.
  localparam logic [wpc_pkg::CfgIdxWidth-1:0] REG_NONE = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE = 45;

  logic clk;
  logic rst;
  int   pending;
  int   errors;
  int   quiet_cycles;
  int   stall_left;
  bit   calm;

  // The bench keeps its own list of the loaded path so it can place the
  // robot close to waypoints and make arrivals happen.
  logic signed [31:0] route_x[$];
  logic signed [31:0] route_y[$];
  int   cursor;

  wpc_item_if   item_ch();
  wpc_result_if result_ch();
  wpc_cfg_if    cfg_ch();

  waypoint_pursuit_controller dut (
    .clk(clk), .rst(rst), .item(item_ch), .result(result_ch), .cfg(cfg_ch)
  );

  waypoint_pursuit_controller_checker checker_i (
    .clk(clk), .rst(rst), .item(item_ch), .result(result_ch), .cfg(cfg_ch),
    .pending(pending), .errors(errors)
  );

  always #10 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 11) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 4);
  endfunction

  function automatic logic signed [31:0] any_coord();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
  endfunction

  // The receiver stalls at random unless the bench asks for a calm stretch.
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      result_ch.ready = 1'b0;
      stall_left--;
    end else begin
      result_ch.ready = 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) stall_left = pick_gap();
    end
  end

  // The watchdog ends the run if no channel moves for too long.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Sends one request; valid stays high after acceptance so back-to-back
  // requests are possible, and is lowered only when a gap follows.
  task automatic send(input logic op, input logic np, input logic signed [31:0] x,
                      input logic signed [31:0] y, input logic signed [15:0] yaw);
    int gap;
    gap = (calm || $urandom_range(0, 2) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.operation = op;
    item_ch.new_path = np;
    item_ch.pos_x = x;
    item_ch.pos_y = y;
    item_ch.heading = yaw;
    item_ch.valid = 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    if (op == wpc_pkg::OP_LOAD) begin
      if (np) begin
        route_x.delete();
        route_y.delete();
        cursor = 0;
      end
      route_x.push_back(x);
      route_y.push_back(y);
    end
  endtask

  // Waits until every predicted command has come out, then lets the block
  // finish any odometry request that yields no command.
  task automatic drain();
    item_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [wpc_pkg::CfgIdxWidth-1:0] idx,
                           input logic [23:0] val);
    cfg_ch.index = idx;
    cfg_ch.data = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_gains(input logic [23:0] gl, input logic [23:0] ga, input logic [23:0] ar);
    drain();
    write_reg(wpc_pkg::REG_LINEAR_GAIN, gl);
    write_reg(wpc_pkg::REG_ANGULAR_GAIN, ga);
    write_reg(wpc_pkg::REG_ARRIVAL, ar);
  endtask

  // Odometry a short way from a waypoint of the path, usually the one the
  // bench guesses is the target.
  task automatic odometry_near();
    int k;
    logic signed [31:0] jx;
    logic signed [31:0] jy;
    if (route_x.size() == 0) return;
    if (cursor >= route_x.size()) cursor = route_x.size() - 1;
    k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, route_x.size() - 1) : cursor;
    jx = $signed($urandom_range(0, 16384)) - 8192;
    jy = $signed($urandom_range(0, 16384)) - 8192;
    send(wpc_pkg::OP_ODOMETRY, 1'($urandom_range(0, 1)), route_x[k] + jx, route_y[k] + jy,
         16'($urandom));
    if (k == cursor && cursor + 1 < route_x.size()) cursor++;
  endtask

  // A fresh path with random content, followed by the robot driving along it.
  task automatic path_run();
    int len;
    int steps;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 16);
    send(wpc_pkg::OP_LOAD, 1'b1, any_coord(), any_coord(), 16'($urandom));
    for (int i = 1; i < len; i++) begin
      send(wpc_pkg::OP_LOAD, 1'b0, any_coord(), any_coord(), 16'($urandom));
    end
    steps = $urandom_range(4, 24);
    for (int i = 0; i < steps; i++) begin
      case ($urandom_range(0, 9))
        0: send(wpc_pkg::OP_ODOMETRY, 1'($urandom_range(0, 1)), $urandom, $urandom,
                16'($urandom));
        1: send(wpc_pkg::OP_LOAD, 1'b0, any_coord(), any_coord(), 16'($urandom));
        default: odometry_near();
      endcase
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    calm = 1'b0;
    cursor = 0;
    item_ch.valid = 1'b0;
    item_ch.operation = wpc_pkg::OP_LOAD;
    item_ch.new_path = 1'b0;
    item_ch.pos_x = '0;
    item_ch.pos_y = '0;
    item_ch.heading = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = wpc_pkg::REG_LINEAR_GAIN;
    cfg_ch.data = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed part at reset defaults. Odometry before any load is dropped.
    send(wpc_pkg::OP_ODOMETRY, 1'b0, 32'sd0, 32'sd0, 16'sd0);
    send(wpc_pkg::OP_LOAD, 1'b1, 32'sd0, 32'sd0, 16'sd0);
    // A zero offset has bearing zero; the yaw extremes wrap the error.
    send(wpc_pkg::OP_ODOMETRY, 1'b0, 32'sd0, 32'sd0, 16'sd0);
    send(wpc_pkg::OP_ODOMETRY, 1'b0, 32'sd0, 32'sd0, -16'sd32768);
    send(wpc_pkg::OP_ODOMETRY, 1'b0, 32'sd0, 32'sd0, 16'sd32767);
    // Offsets in the first and third quadrants, and straight behind.
    send(wpc_pkg::OP_ODOMETRY, 1'b0, 32'sd65536, 32'sd0, 16'sd0);
    send(wpc_pkg::OP_ODOMETRY, 1'b0, -32'sd65536, -32'sd65536, 16'sd16384);
    send(wpc_pkg::OP_ODOMETRY, 1'b0, 32'sd65536, 32'sd65536, -16'sd16384);
    // New path flag on odometry is ignored.
    send(wpc_pkg::OP_ODOMETRY, 1'b1, 32'sd1000, -32'sd1000, 16'sd100);
    // Appending while following keeps the target.
    send(wpc_pkg::OP_LOAD, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 16'sd0);
    send(wpc_pkg::OP_ODOMETRY, 1'b0, 32'sd0, 32'sd0, 16'sd0);
    send(wpc_pkg::OP_ODOMETRY, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, -16'sd1);
    send(wpc_pkg::OP_ODOMETRY, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sd1);

    // Extreme gains and the widest arrival radius.
    set_gains(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    write_reg(REG_NONE, 24'hAB_CDEF);
    send(wpc_pkg::OP_ODOMETRY, 1'b0, 32'sd0, 32'sd0, 16'sd0);
    send(wpc_pkg::OP_ODOMETRY, 1'b0, 32'sd0, 32'sd0, 16'sd12345);
    send(wpc_pkg::OP_ODOMETRY, 1'b0, 32'h4000_0000, 32'sd0, 16'sd0);
    set_gains(24'd0, 24'd0, 24'd0);
    send(wpc_pkg::OP_ODOMETRY, 1'b0, 32'sd12345, 32'sd0, 16'sd300);
    send(wpc_pkg::OP_ODOMETRY, 1'b0, 32'sd0, 32'sd0, 16'sd0);

    // Fill the table past its depth; the extra waypoints are dropped.
    set_gains(24'd65536, 24'd131072, 24'hFF_FFFF);
    calm = 1'b1;
    send(wpc_pkg::OP_LOAD, 1'b1, 32'sd0, 32'sd0, 16'sd0);
    for (int i = 1; i < 260; i++) send(wpc_pkg::OP_LOAD, 1'b0, i * 1000, -i * 1000, 16'sd0);
    calm = 1'b0;
    for (int i = 0; i < 8; i++) begin
      send(wpc_pkg::OP_ODOMETRY, 1'b0, any_coord(), any_coord(), 16'($urandom));
    end

    // Random phases, each with its own gains, some of them extreme.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_gains(wpc_pkg::LINEAR_GAIN_RESET, wpc_pkg::ANGULAR_GAIN_RESET,
                     wpc_pkg::ARRIVAL_RESET);
        1: set_gains(24'hFF_FFFF, 24'd1, 24'd16384);
        2: set_gains(24'd1, 24'hFF_FFFF, 24'd0);
        default: set_gains(24'($urandom), 24'($urandom), 24'($urandom_range(0, 1 << 16)));
      endcase
      // One phase runs with no random request gaps and no new random receiver stalls.
      calm = (ph == 3);
      while ($urandom_range(0, 11) != 0 || ph < 2) begin
        path_run();
        if ($urandom_range(0, 5) == 0) drain();
        if ($urandom_range(0, 2) == 0) break;
      end
      for (int n = 0; n < 3; n++) path_run();
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
